// ===== sv/gcrt_pkg.sv =====
// ----------------------------------------------------------------------------
// gcrt_pkg
// Shared constants, types and the CORDIC arctangent table for the tracer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gcrt_pkg;

  localparam int MAP_SIDE     = 64;
  localparam int FRAC_BITS    = 10;
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_ENTRIES = 24;
  localparam int MAX_CELLS    = 64;

  localparam int CNT_W  = $clog2(MAX_CELLS);
  localparam int SIDE_W = 7;
  localparam int POS_W  = 18;   // signed position, Q6.10 plus sign and overflow
  localparam int MAG_W  = 32;   // CORDIC magnitude width
  localparam int IDX_W  = $clog2(CORDIC_STEPS + 1);

  // register indexes
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_DIV,
    ST_CHECK,
    ST_WALK
  } state_e;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] turn_atan(input logic [IDX_W-1:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'd536870912;
      5'd1:  t = 32'd316933406;
      5'd2:  t = 32'd167458907;
      5'd3:  t = 32'd85004756;
      5'd4:  t = 32'd42667331;
      5'd5:  t = 32'd21354465;
      5'd6:  t = 32'd10679838;
      5'd7:  t = 32'd5340245;
      5'd8:  t = 32'd2670163;
      5'd9:  t = 32'd1335087;
      5'd10: t = 32'd667544;
      5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;
      5'd13: t = 32'd83443;
      5'd14: t = 32'd41722;
      5'd15: t = 32'd20861;
      5'd16: t = 32'd10430;
      5'd17: t = 32'd5215;
      5'd18: t = 32'd2608;
      5'd19: t = 32'd1304;
      5'd20: t = 32'd652;
      5'd21: t = 32'd326;
      5'd22: t = 32'd163;
      5'd23: t = 32'd81;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== sv/gcrt_cordic.sv =====
// ----------------------------------------------------------------------------
// gcrt_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcrt_cordic import gcrt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [13:0]      r_i,
  output logic                  done_o,
  output logic [MAG_W-1:0]      cos_o,
  output logic [MAG_W-1:0]      sin_o
);

  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [32:0] z_q, z_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic signed [33:0] dx, dy;
  logic signed [32:0] ang;

  // one micro-rotation
  always_comb begin
    dx     = x_q;
    dy     = y_q;
    dx     = y_q >>> idx_q;
    dy     = x_q >>> idx_q;
    ang    = $signed({1'b0, turn_atan(idx_q)});
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = 34'sd1 <<< 30;
      y_d    = '0;
      z_d    = $signed({3'b0, r_i, 16'b0});
      idx_d  = '0;
      busy_d = (r_i != 14'd0);
      done_d = (r_i == 14'd0);
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - ang;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + ang;
      end
      idx_d = idx_q + 1'b1;
      if (idx_q == IDX_W'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  // negatives clamp to zero
  assign done_o = done_q;
  assign cos_o  = x_q[33] ? '0 : x_q[MAG_W-1:0];
  assign sin_o  = y_q[33] ? '0 : y_q[MAG_W-1:0];

endmodule

`default_nettype wire

// ===== sv/gcrt_div.sv =====
// ----------------------------------------------------------------------------
// gcrt_div
// Restoring divider for the Q0.16 slope, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcrt_div import gcrt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [MAG_W-1:0] num_i,
  input  wire logic [MAG_W-1:0] den_i,
  output logic                  done_o,
  output logic [15:0]           quo_o
);

  logic [MAG_W:0]   rem_q, rem_d, den_q, den_d;
  logic [15:0]      quo_q, quo_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [MAG_W:0]   shl;

  always_comb begin
    shl    = {rem_q[MAG_W-1:0], 1'b0};
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = {1'b0, num_i};
      den_d = {1'b0, den_i};
      quo_d = 16'hFFFF;
      cnt_d = '0;
      // zero divisor or quotient of one or more saturates
      if (den_i == '0 || num_i >= den_i) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (shl >= den_q) begin
        rem_d = shl - den_q;
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = shl;
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == 5'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== sv/grid_ray_cell_tracer_core.sv =====
// ----------------------------------------------------------------------------
// grid_ray_cell_tracer_core
// Traces a ray over a grid and lists the visited cell indexes.
// ----------------------------------------------------------------------------
//  channel | signals                                    | dir
//  in      | in_valid_i, in_stall_o, start_col/row, hdg | request in
//  out     | out_valid_o, out_stall_i, cell_index, last | request out
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i          | write only
//
//  Per request: accept, CORDIC, divider and start check in that order, then one
//  cell per cycle (up to 64) from the walker while the output is not stalled.
//  Output stalls hold the walker; input is stalled until the walk ends.
//  Reset sets both map dimensions to 64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_ray_cell_tracer_core import gcrt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [SIDE_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [15:0]       start_col_i,
  input  wire logic [15:0]       start_row_i,
  input  wire logic [15:0]       heading_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [11:0]            cell_index_o,
  output logic                   last_cell_o
);

  state_e state_q, state_d;

  logic [SIDE_W-1:0] wreg_q, hreg_q, w, ht;
  logic [15:0]       hdg_q;
  logic signed [POS_W-1:0] pc_q, pr_q, pc_n, pr_n;
  logic [17:0]       err_q, err_sum;
  logic [15:0]       ratio_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              out_valid_q, last_q;
  logic [11:0]       cell_q;

  logic              in_acc, cor_done, div_done, x_major, cpos, rpos;
  logic              cur_out, nxt_out, out_free, last_n, minor_mv;
  logic [1:0]        q;
  logic [13:0]       r;
  logic [MAG_W-1:0]  cs, sn, mag_s, mag_c, minor, major;
  logic [15:0]       quo;
  logic [POS_W-1:0]  wlim, hlim;
  logic [11:0]       cell_n;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wreg_q <= SIDE_W'(MAP_SIDE);
      hreg_q <= SIDE_W'(MAP_SIDE);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_MAP_WIDTH) wreg_q <= cfg_data_i;
      if (cfg_index_i == REG_MAP_HEIGHT) hreg_q <= cfg_data_i;
    end
  end

  // clamp dimensions to 1..MAP_SIDE
  always_comb begin
    w  = (wreg_q == '0) ? SIDE_W'(1) : (wreg_q > SIDE_W'(MAP_SIDE)) ? SIDE_W'(MAP_SIDE) : wreg_q;
    ht = (hreg_q == '0) ? SIDE_W'(1) : (hreg_q > SIDE_W'(MAP_SIDE)) ? SIDE_W'(MAP_SIDE) : hreg_q;
    wlim = POS_W'({w, {FRAC_BITS{1'b0}}});
    hlim = POS_W'({ht, {FRAC_BITS{1'b0}}});
  end

  assign in_acc = in_valid_i && !in_stall_o;
  assign q      = hdg_q[15:14];
  assign r      = hdg_q[13:0];
  assign cpos   = (hdg_q < 16'd16384) || (hdg_q > 16'd49152);
  assign rpos   = (hdg_q != 16'd0) && (hdg_q < 16'd32768);
  assign x_major = q[0] ? (r > 14'd8192) : (r < 14'd8192);

  gcrt_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .r_i     (heading_i[13:0]),
    .done_o  (cor_done),
    .cos_o   (cs),
    .sin_o   (sn)
  );

  // axis selection
  always_comb begin
    mag_s = q[0] ? cs : sn;
    mag_c = q[0] ? sn : cs;
    minor = x_major ? mag_s : mag_c;
    major = x_major ? mag_c : mag_s;
  end

  gcrt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_done),
    .num_i   (minor),
    .den_i   (major),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // walker: current cell and next position
  always_comb begin
    cur_out  = pc_q[POS_W-1] || pr_q[POS_W-1] ||
               ($unsigned(pc_q) >= wlim) || ($unsigned(pr_q) >= hlim);
    cell_n   = 12'(({6'b0, pr_q[FRAC_BITS +: 6]} * {5'b0, w}) + {6'b0, pc_q[FRAC_BITS +: 6]});
    err_sum  = err_q + {2'b0, ratio_q};
    minor_mv = err_sum > 18'd65536;
    pc_n = pc_q;
    pr_n = pr_q;
    if (x_major) begin
      pc_n = cpos ? pc_q + POS_W'(1 << FRAC_BITS) : pc_q - POS_W'(1 << FRAC_BITS);
      if (minor_mv) pr_n = rpos ? pr_q + POS_W'(1 << FRAC_BITS) : pr_q - POS_W'(1 << FRAC_BITS);
    end else begin
      pr_n = rpos ? pr_q + POS_W'(1 << FRAC_BITS) : pr_q - POS_W'(1 << FRAC_BITS);
      if (minor_mv) pc_n = cpos ? pc_q + POS_W'(1 << FRAC_BITS) : pc_q - POS_W'(1 << FRAC_BITS);
    end
    nxt_out  = pc_n[POS_W-1] || pr_n[POS_W-1] ||
               ($unsigned(pc_n) >= wlim) || ($unsigned(pr_n) >= hlim);
    last_n   = nxt_out || (cnt_q == CNT_W'(MAX_CELLS - 1));
    out_free = !out_valid_q || !out_stall_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_ROT;
      ST_ROT:   if (cor_done) state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_CHECK;
      ST_CHECK: state_d = cur_out ? ST_IDLE : ST_WALK;
      ST_WALK:  if (out_free && last_n) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_WALK && out_free) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_q + 1'b1;
      end else begin
        if (!out_stall_i) out_valid_q <= 1'b0;
        if (state_q == ST_CHECK) cnt_q <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hdg_q <= heading_i;
      pc_q  <= POS_W'(start_col_i);
      pr_q  <= POS_W'(start_row_i);
    end
    if (div_done) begin
      ratio_q <= quo;
      err_q   <= 18'({(x_major ? pr_q[FRAC_BITS-1:0] : pc_q[FRAC_BITS-1:0]),
                      {(16 - FRAC_BITS){1'b0}}});
    end
    if (state_q == ST_WALK && out_free) begin
      cell_q <= cell_n;
      last_q <= last_n;
      pc_q   <= pc_n;
      pr_q   <= pr_n;
      err_q  <= minor_mv ? err_sum - 18'd65536 : err_sum;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_index_o = cell_q;
  assign last_cell_o  = last_q;

endmodule

`default_nettype wire
